@@ rtl/rgbhsl_pkg.sv @@
package rgbhsl_pkg;

    // Channel and fraction widths fixed by the pixel and result formats.
    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    localparam int CH_MAX = (1 << CHANNEL_BITS) - 1;

    // Divider remainder and divisor width: wide enough for 6 * spread.
    localparam int DIV_W  = CHANNEL_BITS + 3;
    localparam int SUM_W  = CHANNEL_BITS + 1;
    localparam int DIFF_W = CHANNEL_BITS + 1;
    localparam int HUE_W  = CHANNEL_BITS + 4;
    localparam int SN_W   = CHANNEL_BITS + FRACTION_BITS;
    // Sum times (2^CHANNEL_BITS + 1), before the final halving.
    localparam int LN_W   = SUM_W + CHANNEL_BITS;

    // Front end stages plus one divider stage per quotient bit plus output.
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_LATENCY = FRONT_STAGES + FRACTION_BITS + 1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_rgb_t;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS-1:0] saturation;
        logic [FRACTION_BITS-1:0] lightness;
    } pixel_hsl_t;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    // One lane of the restoring divider. The partial remainder sits in rem,
    // the numerator bits not yet consumed sit in the top of work, and the
    // quotient bits shift into the bottom of work.
    typedef struct packed {
        logic [DIV_W-1:0]         rem;
        logic [FRACTION_BITS-1:0] work;
        logic [DIV_W-1:0]         divisor;
    } div_lane_t;

    // Lightness is already final when it enters the divider and rides along.
    typedef struct packed {
        div_lane_t                hue;
        div_lane_t                sat;
        logic [FRACTION_BITS-1:0] lit;
        logic                     gray;
    } div_item_t;

    // One quotient bit of a restoring division.
    function automatic div_lane_t div_step(input div_lane_t x);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] dvs;
        div_lane_t      y;
        trial = {x.rem, x.work[FRACTION_BITS-1]};
        dvs   = {1'b0, x.divisor};
        y     = x;
        if (trial >= dvs) begin
            y.rem  = DIV_W'(trial - dvs);
            y.work = {x.work[FRACTION_BITS-2:0], 1'b1};
        end else begin
            y.rem  = trial[DIV_W-1:0];
            y.work = {x.work[FRACTION_BITS-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

@@ rtl/rgbhsl_front.sv @@
module rgbhsl_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  rgbhsl_pkg::pixel_rgb_t in_pixel,
    output logic                   out_valid,
    output rgbhsl_pkg::div_item_t  out_item
);

    localparam int C = rgbhsl_pkg::CHANNEL_BITS;
    localparam int F = rgbhsl_pkg::FRACTION_BITS;

    // Stage 1: largest and smallest channel, which channel wins, hue difference.
    logic                                   v1_reg;
    logic [C-1:0]                           mx1_reg, mx1_next;
    logic [C-1:0]                           mn1_reg, mn1_next;
    rgbhsl_pkg::max_sel_t                   sel1_reg, sel1_next;
    logic signed [rgbhsl_pkg::DIFF_W-1:0]   diff1_reg, diff1_next;

    // Stage 2: spread and sum.
    logic                                   v2_reg;
    logic [C-1:0]                           d2_reg, d2_next;
    logic [rgbhsl_pkg::SUM_W-1:0]           sum2_reg, sum2_next;
    rgbhsl_pkg::max_sel_t                   sel2_reg;
    logic signed [rgbhsl_pkg::DIFF_W-1:0]   diff2_reg;

    // Stage 3: numerators and divisors for the two divider lanes, and lightness.
    logic                                   v3_reg;
    rgbhsl_pkg::div_item_t                  item3_reg, item3_next;

    always_comb begin
        logic [C-1:0] r, g, b;
        r = in_pixel.red;
        g = in_pixel.green;
        b = in_pixel.blue;
        if (r >= g && r >= b) begin
            sel1_next  = rgbhsl_pkg::MAX_RED;
            mx1_next   = r;
            diff1_next = $signed({1'b0, g}) - $signed({1'b0, b});
        end else if (g >= b) begin
            sel1_next  = rgbhsl_pkg::MAX_GREEN;
            mx1_next   = g;
            diff1_next = $signed({1'b0, b}) - $signed({1'b0, r});
        end else begin
            sel1_next  = rgbhsl_pkg::MAX_BLUE;
            mx1_next   = b;
            diff1_next = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        mn1_next = r;
        if (g < mn1_next) mn1_next = g;
        if (b < mn1_next) mn1_next = b;
    end

    always_comb begin
        d2_next   = mx1_reg - mn1_reg;
        sum2_next = {1'b0, mx1_reg} + {1'b0, mn1_reg};
    end

    always_comb begin
        logic signed [rgbhsl_pkg::HUE_W-1:0] d_s, diff_s, base_s, num_s, six_s;
        logic [rgbhsl_pkg::SUM_W-1:0]        den;
        logic [rgbhsl_pkg::SN_W-1:0]         sat_num;
        logic [rgbhsl_pkg::LN_W-1:0]         lit_num;

        d_s    = $signed(rgbhsl_pkg::HUE_W'(d2_reg));
        diff_s = rgbhsl_pkg::HUE_W'(diff2_reg);
        six_s  = (d_s <<< 2) + (d_s <<< 1);
        case (sel2_reg)
            rgbhsl_pkg::MAX_RED:   base_s = '0;
            rgbhsl_pkg::MAX_GREEN: base_s = d_s <<< 1;
            rgbhsl_pkg::MAX_BLUE:  base_s = d_s <<< 2;
            default:               base_s = '0;
        endcase
        num_s = base_s + diff_s;
        // A negative hue wraps by one full turn.
        if (num_s < 0) num_s = num_s + six_s;

        item3_next.hue.rem     = num_s[rgbhsl_pkg::DIV_W-1:0];
        item3_next.hue.work    = '0;
        item3_next.hue.divisor = six_s[rgbhsl_pkg::DIV_W-1:0];

        // Below half lightness the saturation divides by the sum, otherwise
        // by its complement to twice full scale.
        if (sum2_reg < rgbhsl_pkg::SUM_W'(rgbhsl_pkg::CH_MAX)) begin
            den = sum2_reg;
        end else begin
            den = rgbhsl_pkg::SUM_W'(2 * rgbhsl_pkg::CH_MAX) - sum2_reg;
        end
        sat_num = {d2_reg, {F{1'b0}}} - rgbhsl_pkg::SN_W'(d2_reg);
        item3_next.sat.rem     = rgbhsl_pkg::DIV_W'(sat_num[rgbhsl_pkg::SN_W-1:F]);
        item3_next.sat.work    = sat_num[F-1:0];
        item3_next.sat.divisor = rgbhsl_pkg::DIV_W'(den);

        // With the fraction twice as wide as a channel, the full-scale ratio
        // (2^F - 1) / (2 * (2^C - 1)) is exactly (2^C + 1) / 2, so lightness
        // is the sum times (2^C + 1), halved and truncated.
        lit_num = {sum2_reg, {C{1'b0}}} + rgbhsl_pkg::LN_W'(sum2_reg);
        item3_next.lit = lit_num[F:1];

        item3_next.gray = (d2_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mx1_reg   <= mx1_next;
            mn1_reg   <= mn1_next;
            sel1_reg  <= sel1_next;
            diff1_reg <= diff1_next;
            d2_reg    <= d2_next;
            sum2_reg  <= sum2_next;
            sel2_reg  <= sel1_reg;
            diff2_reg <= diff1_reg;
            item3_reg <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

@@ rtl/rgbhsl_div_pipe.sv @@
module rgbhsl_div_pipe (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  rgbhsl_pkg::div_item_t in_item,
    output logic                  out_valid,
    output rgbhsl_pkg::div_item_t out_item
);

    localparam int F = rgbhsl_pkg::FRACTION_BITS;

    // One stage per quotient bit; both lanes step side by side and the
    // lightness rides along unchanged.
    logic                  valid_reg [F];
    rgbhsl_pkg::div_item_t stage_reg [F];
    rgbhsl_pkg::div_item_t stage_next [F];

    always_comb begin
        for (int i = 0; i < F; i++) begin
            rgbhsl_pkg::div_item_t src;
            src = (i == 0) ? in_item : stage_reg[(i == 0) ? 0 : i - 1];
            stage_next[i].hue  = rgbhsl_pkg::div_step(src.hue);
            stage_next[i].sat  = rgbhsl_pkg::div_step(src.sat);
            stage_next[i].lit  = src.lit;
            stage_next[i].gray = src.gray;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < F; i++) valid_reg[i] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < F; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < F; i++) stage_reg[i] <= stage_next[i];
        end
    end

    assign out_valid = valid_reg[F-1];
    assign out_item  = stage_reg[F-1];

endmodule

@@ rtl/rgb_to_hsl_convert.sv @@
// RGB to HSL conversion, one pixel per transfer.
// The input channel (s_valid, s_ready, s_data) carries 8-bit red, green and
// blue. The result channel (m_valid, m_ready, m_data) carries hue as a
// fraction of a full turn times 65536, and saturation and lightness as
// fractions times 65535, all truncated toward zero. A gray pixel gives hue
// and saturation of zero. Pixels are independent; nothing is kept between
// them.
// Throughput is one pixel per clock while the output is not stalled. An
// input transfer reaches its result through three front-end stages
// (extremes; spread and sum; divider numerators and divisors, with lightness
// finished there as a constant scaling of the sum), sixteen restoring divider
// stages that each produce one quotient bit of hue and of saturation, and the
// output register; the divider depth is one stage per result bit.
// The whole pipeline moves while the output register is empty or its result
// is being taken, so s_ready falls only while a result waits on a stalled
// receiver; no pixel is dropped or repeated across a stall.
// Reset (aresetn low at a clock edge) clears every valid bit, so the block
// comes out of reset empty with m_valid low.
module rgb_to_hsl_convert (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rgbhsl_pkg::pixel_rgb_t s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rgbhsl_pkg::pixel_hsl_t m_data
);

    // Pipeline advance: the output register can take a new result.
    logic adv;

    logic                  front_valid;
    rgbhsl_pkg::div_item_t front_item;
    logic                  div_valid;
    rgbhsl_pkg::div_item_t div_item;

    logic                   m_valid_reg;
    rgbhsl_pkg::pixel_hsl_t hsl_reg, hsl_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    rgbhsl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_pixel  (s_data),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    rgbhsl_div_pipe u_div_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // After the last divider stage each lane's work field holds its quotient.
    // A gray pixel has no defined hue and no saturation, so both are forced
    // to zero here; the divider output for those lanes is meaningless then.
    always_comb begin
        hsl_next.hue        = div_item.gray ? '0 : div_item.hue.work;
        hsl_next.saturation = div_item.gray ? '0 : div_item.sat.work;
        hsl_next.lightness  = div_item.lit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hsl_reg <= hsl_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = hsl_reg;

    // Reset leaves the result channel empty on the following cycle.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Any pixel that is not gray has nonzero saturation, so zero saturation
    // with a nonzero hue means the gray masking or a divider lane slipped.
    a_gray_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturation == '0 |-> m_data.hue == '0)
        else $error("hue without saturation");

    // Zero lightness only comes from a black pixel.
    a_black_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lightness == '0 |-> m_data.saturation == '0 && m_data.hue == '0)
        else $error("black pixel with color");

    // A result leaving the divider while the pipeline moves lands in the
    // output register.
    a_div_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && div_valid |=> m_valid)
        else $error("result lost between divider and output");

endmodule
